@@ design/skpc_pkg.sv @@
// ----------------------------------------------------------------------------
// skpc_pkg: shared types and constants for the soft-knee peak compressor
// Holds the configuration record, sequencer states, 2^(2^-(k+1)) root
// table and the round-half-away-from-zero shift helper.
// ----------------------------------------------------------------------------
package skpc_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 3'd6;

    // report width and fixed-point constants
    localparam int GR_W = 14;
    localparam logic signed [16:0] LEVEL_FLOOR = -17'sd51200;
    localparam logic [19:0] DB_PER_LOG2 = 20'd394566;
    localparam logic [21:0] LOG2_PER_DB = 22'd2786635;

    typedef struct packed {
        logic signed [14:0] threshold;
        logic [16:0]        inv_ratio;
        logic [12:0]        knee;
        logic [15:0]        attack;
        logic [15:0]        rel_coeff;
        logic [18:0]        makeup;
        logic               bypass;
    } t_cfg;

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_NORM  = 21'h000002,
        S_SQ    = 21'h000004,
        S_LVL   = 21'h000008,
        S_LVLW  = 21'h000010,
        S_GAIN  = 21'h000020,
        S_HARD  = 21'h000040,
        S_SOFT1 = 21'h000080,
        S_SOFT2 = 21'h000100,
        S_SOFT3 = 21'h000200,
        S_DIV   = 21'h000400,
        S_ENV   = 21'h000800,
        S_ENVW  = 21'h001000,
        S_EXP   = 21'h002000,
        S_EXPW  = 21'h004000,
        S_ROOT  = 21'h008000,
        S_MUL1  = 21'h010000,
        S_MUL2  = 21'h020000,
        S_SCALE = 21'h040000,
        S_SAT   = 21'h080000,
        S_DONE  = 21'h100000
    } t_state;

    typedef logic [15:0][30:0] t_root_tab;

    // successive square roots of 2 in Q1.30, truncating integer square root
    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        tab = '0;
        c   = 64'd1 << 31;
        for (int k = 0; k < 16; k++) begin
            v = c << 30;
            r = '0;
            b = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (b > v) b = b >> 2;
            end
            for (int j = 0; j < 32; j++) begin
                if (b != 64'd0) begin
                    if (v >= r + b) begin
                        v = v - (r + b);
                        r = (r >> 1) + b;
                    end else begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
            end
            c      = r;
            tab[k] = c[30:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

    // divide by 2^sh, rounding half away from zero
    function automatic logic signed [PROD_W-1:0] f_rnd_shr(
        input logic signed [PROD_W-1:0] v,
        input int                       sh
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        q   = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
        return v[PROD_W-1] ? $signed(-q) : $signed(q);
    endfunction

endpackage

@@ design/skpc_mul.sv @@
// ----------------------------------------------------------------------------
// skpc_mul: shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module skpc_mul (
    input  logic                                i_clk,
    input  logic signed [skpc_pkg::MUL_W-1:0]   i_a,
    input  logic signed [skpc_pkg::MUL_W-1:0]   i_b,
    output logic signed [skpc_pkg::PROD_W-1:0]  o_p
);
    import skpc_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    // register the product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ design/skpc_core.sv @@
// ----------------------------------------------------------------------------
// skpc_core: sequencer and datapath around the shared multiplier
// Computes level, gain computer, envelope, linear gain and scaled samples of
// one frame, one step per cycle until it waits in done; bypass skips to done.
// ----------------------------------------------------------------------------
module skpc_core #(
    parameter int SAMPLE_BITS     = 24,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  skpc_pkg::t_cfg                i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_s0,
    input  logic signed [SAMPLE_BITS-1:0] i_s1,
    input  logic                          i_last,
    input  logic                          i_take,
    output logic                          o_busy,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_y0,
    output logic signed [SAMPLE_BITS-1:0] o_y1,
    output logic [skpc_pkg::GR_W-1:0]     o_gr,
    output logic                          o_last
);
    import skpc_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int LB = $clog2(LOG_TABLE_DEPTH);
    localparam int EW = $clog2(SAMPLE_BITS);
    localparam logic [63:0] SAT_HI = (64'd1 << (SB - 1)) - 64'd1;
    localparam logic signed [PROD_W-1:0] G_MAX = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] G_MIN = -(PROD_W'(32768));

    t_state                 r_state;
    logic [4:0]             r_cnt;
    logic signed [SB-1:0]   r_s0;
    logic signed [SB-1:0]   r_s1;
    logic                   r_last;
    logic [SB-1:0]          r_norm;
    logic [EW-1:0]          r_e;
    logic [31:0]            r_x;
    logic [15:0]            r_f;
    logic signed [16:0]     r_level;
    logic [14:0]            r_y;
    logic [27:0]            r_rem;
    logic [25:0]            r_dvs;
    logic [13:0]            r_q;
    logic                   r_neg;
    logic signed [15:0]     r_tgt;
    logic signed [15:0]     r_env;
    logic signed [15:0]     r_min;
    logic [GR_W-1:0]        r_rep;
    logic signed [7:0]      r_sh;
    logic [30:0]            r_g;
    logic                   r_pend;
    logic                   r_ch;
    logic [63:0]            r_mag;
    logic signed [SB-1:0]   r_y0;
    logic signed [SB-1:0]   r_y1;

    logic signed [MUL_W-1:0]  w_ma;
    logic signed [MUL_W-1:0]  w_mb;
    logic signed [PROD_W-1:0] w_prod;

    logic [SB-1:0]            w_abs0;
    logic [SB-1:0]            w_abs1;
    logic [SB-1:0]            w_peak;
    logic [31:0]              w_t;
    logic [31:0]              w_xeff;
    logic signed [EW+1:0]     w_ediff;
    logic signed [EW+17:0]    w_l2;
    logic signed [17:0]       w_d;
    logic signed [19:0]       w_d2;
    logic signed [19:0]       w_k;
    logic signed [19:0]       w_ysum;
    logic signed [17:0]       w_r;
    logic signed [PROD_W-1:0] w_rnd16;
    logic signed [PROD_W-1:0] w_rnd24;
    logic signed [PROD_W-1:0] w_rnd30;
    logic [PROD_W-1:0]        w_pmag;
    logic [PROD_W-1:0]        w_nsum;
    logic                     w_ge;
    logic [13:0]              w_qn;
    logic signed [16:0]       w_diff;
    logic [15:0]              w_c;
    logic signed [17:0]       w_esum;
    logic signed [15:0]       w_envn;
    logic signed [15:0]       w_minn;
    logic signed [16:0]       w_negmin;
    logic [30:0]              w_geff;
    logic [5:0]               w_shu;
    logic [4:0]               w_shl;
    logic [63:0]              w_smag;
    logic signed [SB-1:0]     w_sat;
    logic signed [SB-1:0]     w_ssel;

    skpc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // peak magnitude of the frame
    always_comb begin
        w_abs0 = i_s0[SB-1] ? SB'(~i_s0 + 1'b1) : SB'(i_s0);
        w_abs1 = i_s1[SB-1] ? SB'(~i_s1 + 1'b1) : SB'(i_s1);
        w_peak = (w_abs1 > w_abs0) ? w_abs1 : w_abs0;
    end

    // log2 fraction by repeated squaring
    always_comb begin
        w_t    = w_prod[61:30];
        w_xeff = (r_cnt == 5'd0) ? r_x : (w_t[31] ? (w_t >> 1) : w_t);
        w_ediff = $signed({2'b00, r_e}) - $signed((EW + 2)'(SB - 1));
        w_l2    = {w_ediff, r_f};
    end

    // gain computer terms
    always_comb begin
        w_d    = 18'(r_level) - 18'(i_cfg.threshold);
        w_d2   = 20'(w_d) <<< 1;
        w_k    = $signed({7'd0, i_cfg.knee});
        w_ysum = w_d2 + w_k;
        w_r    = $signed({1'b0, i_cfg.inv_ratio}) - 18'sd65536;
    end

    // shared rounding shifts and soft-knee division set-up
    always_comb begin
        w_rnd16 = f_rnd_shr(w_prod, 16);
        w_rnd24 = f_rnd_shr(w_prod, 24);
        w_rnd30 = f_rnd_shr(w_prod, 30);
        w_pmag  = w_prod[PROD_W-1] ? PROD_W'(-w_prod) : PROD_W'(w_prod);
        w_nsum  = (w_pmag + (PROD_W'(i_cfg.knee) << 18)) >> 19;
        w_ge    = r_rem >= {2'b00, r_dvs};
        w_qn    = {r_q[12:0], w_ge};
    end

    // envelope and block minimum
    always_comb begin
        w_diff   = 17'(r_env) - 17'(r_tgt);
        w_c      = (r_tgt < r_env) ? i_cfg.attack : i_cfg.rel_coeff;
        w_esum   = 18'(r_tgt) + w_rnd16[17:0];
        w_envn   = w_esum[15:0];
        w_minn   = (w_envn < r_min) ? w_envn : r_min;
        w_negmin = -(17'(w_minn));
    end

    // linear gain, scaling and saturation
    always_comb begin
        w_geff = r_pend ? w_prod[60:30] : r_g;
        w_shu  = r_sh[5:0];
        w_shl  = 5'(-r_sh);
        if (r_sh > 8'sd0) begin
            w_smag = (w_pmag[63:0] + (64'd1 << (w_shu - 6'd1))) >> w_shu;
        end else begin
            w_smag = w_pmag[63:0] << w_shl;
        end
        if (r_neg) begin
            w_sat = (r_mag > SAT_HI + 64'd1) ? SB'(SAT_HI + 64'd1) : SB'(-r_mag);
        end else begin
            w_sat = (r_mag > SAT_HI) ? SB'(SAT_HI) : SB'(r_mag);
        end
        w_ssel = r_ch ? r_s1 : r_s0;
    end

    // select multiplier operands for the current step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQ: begin
                w_ma = MUL_W'(w_xeff);
                w_mb = MUL_W'(w_xeff);
            end
            S_LVL: begin
                w_ma = MUL_W'(w_l2);
                w_mb = MUL_W'(DB_PER_LOG2);
            end
            S_GAIN: begin
                w_ma = MUL_W'(w_d);
                w_mb = MUL_W'(w_r);
            end
            S_SOFT1: begin
                w_ma = MUL_W'(r_y);
                w_mb = MUL_W'(r_y);
            end
            S_SOFT2: begin
                w_ma = w_prod[MUL_W-1:0];
                w_mb = MUL_W'(w_r);
            end
            S_ENV: begin
                w_ma = MUL_W'(w_c);
                w_mb = MUL_W'(w_diff);
            end
            S_EXP: begin
                w_ma = MUL_W'(r_env);
                w_mb = MUL_W'(LOG2_PER_DB);
            end
            S_ROOT: begin
                w_ma = MUL_W'(w_geff);
                w_mb = MUL_W'(ROOT_TAB[r_cnt[3:0]]);
            end
            S_MUL1: begin
                w_ma = MUL_W'(w_ssel);
                w_mb = MUL_W'(r_g);
            end
            S_MUL2: begin
                w_ma = w_rnd30[MUL_W-1:0];
                w_mb = MUL_W'(i_cfg.makeup);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_env   <= '0;
            r_min   <= '0;
            r_rep   <= '0;
            r_pend  <= 1'b0;
            r_ch    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_cfg.bypass) begin
                            r_state <= S_DONE;
                        end else if (w_peak == '0) begin
                            r_state <= S_GAIN;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (r_norm[SB-1]) begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt == 5'd16) begin
                        r_state <= S_LVL;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_LVL:  r_state <= S_LVLW;
                S_LVLW: r_state <= S_GAIN;
                S_GAIN: begin
                    if (i_cfg.knee == '0) begin
                        r_state <= (w_d <= 18'sd0) ? S_ENV : S_HARD;
                    end else if (w_d2 < -w_k) begin
                        r_state <= S_ENV;
                    end else if (w_d2 > w_k) begin
                        r_state <= S_HARD;
                    end else begin
                        r_state <= S_SOFT1;
                    end
                end
                S_HARD:  r_state <= S_ENV;
                S_SOFT1: r_state <= S_SOFT2;
                S_SOFT2: r_state <= S_SOFT3;
                S_SOFT3: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 5'd13) begin
                        r_state <= S_ENV;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_ENV: r_state <= S_ENVW;
                S_ENVW: begin
                    r_env <= w_envn;
                    if (r_last) begin
                        r_rep <= (w_negmin > 17'sd16383) ? GR_W'(16383) : w_negmin[GR_W-1:0];
                        r_min <= '0;
                    end else begin
                        r_min <= w_minn;
                    end
                    r_state <= S_EXP;
                end
                S_EXP: r_state <= S_EXPW;
                S_EXPW: begin
                    r_cnt   <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_cnt == 5'd16) begin
                        r_ch    <= 1'b0;
                        r_state <= S_MUL1;
                    end else begin
                        r_pend <= r_f[15];
                        r_cnt  <= r_cnt + 5'd1;
                    end
                end
                S_MUL1:  r_state <= S_MUL2;
                S_MUL2:  r_state <= S_SCALE;
                S_SCALE: r_state <= S_SAT;
                S_SAT: begin
                    if (r_ch) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= 1'b1;
                        r_state <= S_MUL1;
                    end
                end
                S_DONE: begin
                    if (i_take) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_s0    <= i_s0;
                    r_s1    <= i_s1;
                    r_last  <= i_last;
                    r_y0    <= i_s0;
                    r_y1    <= i_s1;
                    r_norm  <= w_peak;
                    r_e     <= EW'(SB - 1);
                    r_level <= LEVEL_FLOOR;
                end
            end
            S_NORM: begin
                if (r_norm[SB-1]) begin
                    r_x <= 32'({1'b1, r_norm[SB-2 -: LB]}) << (30 - LB);
                    r_f <= '0;
                end else begin
                    r_norm <= r_norm << 1;
                    r_e    <= r_e - 1'b1;
                end
            end
            S_SQ: begin
                if (r_cnt != 5'd0) r_f <= {r_f[14:0], w_t[31]};
            end
            S_LVLW: r_level <= w_rnd24[16:0];
            S_GAIN: begin
                r_y   <= w_ysum[14:0];
                r_tgt <= '0;
            end
            S_HARD: begin
                if (w_rnd16 > G_MAX) begin
                    r_tgt <= 16'sd32767;
                end else if (w_rnd16 < G_MIN) begin
                    r_tgt <= -16'sd32768;
                end else begin
                    r_tgt <= w_rnd16[15:0];
                end
            end
            S_SOFT3: begin
                r_rem <= w_nsum[27:0];
                r_dvs <= 26'(i_cfg.knee) << 13;
                r_q   <= '0;
                r_neg <= w_prod[PROD_W-1];
            end
            S_DIV: begin
                if (w_ge) r_rem <= r_rem - {2'b00, r_dvs};
                r_dvs <= r_dvs >> 1;
                r_q   <= w_qn;
                if (r_cnt == 5'd13) begin
                    r_tgt <= r_neg ? -(16'(w_qn)) : 16'(w_qn);
                end
            end
            S_EXPW: begin
                r_f  <= w_rnd16[15:0];
                r_sh <= 8'sd12 - 8'($signed(w_rnd16[21:16]));
                r_g  <= 31'd1 << 30;
            end
            S_ROOT: begin
                r_g <= w_geff;
                r_f <= r_f << 1;
            end
            S_SCALE: begin
                r_mag <= w_smag;
                r_neg <= w_prod[PROD_W-1];
            end
            S_SAT: begin
                if (r_ch) begin
                    r_y1 <= w_sat;
                end else begin
                    r_y0 <= w_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_y0   = r_y0;
    assign o_y1   = r_y1;
    assign o_gr   = r_rep;
    assign o_last = r_last;

endmodule

@@ design/soft_knee_peak_compressor.sv @@
// ----------------------------------------------------------------------------
// soft_knee_peak_compressor: feedforward peak compressor with soft knee
// Stereo frame in, gain-applied frame and block reduction report out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one stereo frame and its
//   last-in-block flag. A transaction completes when valid is high and stall
//   is low. Output channel: o_out_valid / i_out_stall carry the scaled frame,
//   the reduction report of the last completed block and the copied flag.
//   Configuration: i_cfg_valid / o_cfg_ready write register i_cfg_index;
//   ready is always high, unknown indexes are dropped. Write only when idle.
//   Sequencing: one frame is worked by a sequencer around a single registered
//   multiplier; it passes through leading-one search, squaring, then the
//   hard-knee step above the knee or the soft-knee steps with 14 divide
//   steps inside it, the root steps and the scaling of each channel in turn
//   before it reaches the output register; a silent frame skips the log and
//   a bypassed frame goes straight to done. The input opens again once the
//   core is back in idle. o_in_stall stays high until the result moves into
//   the output register; a new frame is taken while that register waits.
//   Reset clears the envelope, block minimum and report, and loads the
//   register defaults (unity ratio, 0 dB threshold, unity makeup).
//   While the receiver stalls, the output register holds its transaction
//   and a finished frame waits in the core.
// ----------------------------------------------------------------------------
module soft_knee_peak_compressor #(
    parameter int SAMPLE_BITS     = 24,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_right,
    input  logic                                  i_last_in_block,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_out_left,
    output logic signed [SAMPLE_BITS-1:0]         o_out_right,
    output logic [skpc_pkg::GR_W-1:0]             o_gain_reduction_db,
    output logic                                  o_last_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [skpc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [skpc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import skpc_pkg::*;

    t_cfg                          r_cfg;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic [GR_W-1:0]               r_out_gr;
    logic                          r_out_last;

    logic                          w_start;
    logic                          w_take;
    logic                          w_busy;
    logic                          w_done;
    logic signed [SAMPLE_BITS-1:0] w_y0;
    logic signed [SAMPLE_BITS-1:0] w_y1;
    logic [GR_W-1:0]               w_gr;
    logic                          w_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= '0;
            r_cfg.inv_ratio <= 17'd65536;
            r_cfg.knee      <= '0;
            r_cfg.attack    <= '0;
            r_cfg.rel_coeff <= '0;
            r_cfg.makeup    <= 19'd4096;
            r_cfg.bypass    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_cfg.threshold <= $signed(i_cfg_data[14:0]);
                REG_INV_RATIO: r_cfg.inv_ratio <= i_cfg_data[16:0];
                REG_KNEE:      r_cfg.knee      <= i_cfg_data[12:0];
                REG_ATTACK:    r_cfg.attack    <= i_cfg_data[15:0];
                REG_RELEASE:   r_cfg.rel_coeff <= i_cfg_data[15:0];
                REG_MAKEUP:    r_cfg.makeup    <= i_cfg_data[18:0];
                REG_BYPASS:    r_cfg.bypass    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // accept a frame whenever the core is idle
    assign o_in_stall = w_busy;
    assign w_start    = i_in_valid && !w_busy;
    assign w_take     = w_done && (!r_out_valid || !i_out_stall);

    skpc_core #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cfg   (r_cfg),
        .i_s0    (i_sample_left),
        .i_s1    (i_sample_right),
        .i_last  (i_last_in_block),
        .i_take  (w_take),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_y0    (w_y0),
        .o_y1    (w_y1),
        .o_gr    (w_gr),
        .o_last  (w_last)
    );

    // output register: load a finished frame, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_left  <= w_y0;
            r_out_right <= w_y1;
            r_out_gr    <= w_gr;
            r_out_last  <= w_last;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_left          = r_out_left;
    assign o_out_right         = r_out_right;
    assign o_gain_reduction_db = r_out_gr;
    assign o_last_out          = r_out_last;

    // an accepted frame keeps the input stalled on the next cycle
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a frame");

    // the output register fills only from a finished frame
    a_fill_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_done))
        else $error("output register loaded without a finished frame");

    // a finished frame waits while the full output register is stalled
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_out_valid && i_out_stall) |=> w_done)
        else $error("finished frame lost while output stalled");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the soft-knee peak compressor
// Drives stereo frames and register writes with random gaps and stalls on
// both sides. A scoreboard class holds a bit-exact fixed-point model of the
// gain path and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module tb;
    import skpc_pkg::*;

    localparam int     SB        = 24;
    localparam int     DEPTH     = 256;
    localparam longint MAX_CYCLES = 3000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic [GR_W-1:0]      gr;
        logic                 last;
    } comp_frame_t;

    // model of the compressor and store of expected output frames
    class compressor_scoreboard;
        comp_frame_t          expected_q[$];
        int                   errors;
        t_cfg                 cfg;
        int                   env_gr;
        int                   block_min;
        logic [GR_W-1:0]      reported;
        longint unsigned      roots[17];

        function new();
            longint unsigned v;
            longint unsigned res;
            longint unsigned b;
            errors    = 0;
            cfg       = '0;
            cfg.inv_ratio = 17'd65536;
            cfg.makeup    = 19'd4096;
            env_gr    = 0;
            block_min = 0;
            reported  = '0;
            roots[0]  = 64'd1 << 31;
            // successive square roots of 2, truncated, Q1.30
            for (int k = 1; k <= 16; k++) begin
                v   = roots[k-1] << 30;
                res = 0;
                b   = 64'd1 << 62;
                while (b > v) b = b >> 2;
                while (b != 0) begin
                    if (v >= res + b) begin
                        v   = v - (res + b);
                        res = (res >> 1) + b;
                    end else begin
                        res = res >> 1;
                    end
                    b = b >> 2;
                end
                roots[k] = res;
            end
        endfunction

        // divide rounding half away from zero
        function longint div_round(longint num, longint den);
            longint unsigned m;
            longint unsigned q;
            m = (num < 0) ? longint'(-num) : num;
            q = (m + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD: cfg.threshold = data[14:0];
                REG_INV_RATIO: cfg.inv_ratio = data[16:0];
                REG_KNEE:      cfg.knee      = data[12:0];
                REG_ATTACK:    cfg.attack    = data[15:0];
                REG_RELEASE:   cfg.rel_coeff = data[15:0];
                REG_MAKEUP:    cfg.makeup    = data[18:0];
                REG_BYPASS:    cfg.bypass    = data[0];
                default: ;
            endcase
        endfunction

        // peak level in Q8.8 dB
        function longint peak_level(longint unsigned peak);
            int unsigned     e;
            longint unsigned frac;
            longint unsigned idx;
            longint unsigned x;
            longint          f16;
            longint          l2;
            if (peak == 0) return -51200;
            e   = 0;
            f16 = 0;
            while ((peak >> (e + 1)) != 0) e++;
            frac = (peak << (32 - e)) - (64'd1 << 32);
            idx  = (frac * DEPTH) >> 32;
            x    = ((DEPTH + idx) << 30) / DEPTH;
            for (int k = 0; k < 16; k++) begin
                x   = (x * x) >> 30;
                f16 = f16 << 1;
                if (x >= (64'd1 << 31)) begin
                    f16 = f16 | 1;
                    x   = x >> 1;
                end
            end
            l2 = (longint'(e) - (SB - 1)) * 65536 + f16;
            return div_round(l2 * 394566, 64'sd1 << 24);
        endfunction

        // target reduction from threshold, ratio and knee
        function longint target_gain(longint lvl);
            longint t;
            longint r;
            longint k;
            longint d;
            longint g;
            longint y;
            t = cfg.threshold;
            r = longint'(cfg.inv_ratio) - 65536;
            k = cfg.knee;
            d = lvl - t;
            if (k == 0) g = (d <= 0) ? 0 : div_round(d * r, 65536);
            else if (2 * d < -k) g = 0;
            else if (2 * d > k) g = div_round(d * r, 65536);
            else begin
                y = 2 * d + k;
                g = div_round(y * y * r, k << 19);
            end
            if (g < -32768) g = -32768;
            if (g > 32767) g = 32767;
            return g;
        endfunction

        function void note_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r_in,
                                 logic last);
            comp_frame_t     fr;
            longint          s[2];
            longint unsigned peak;
            longint unsigned mag;
            longint          tgt;
            longint          c;
            longint          p;
            longint          n;
            longint          f;
            longint unsigned lin;
            longint          sh;
            longint          v;
            longint          g;
            s[0] = l;
            s[1] = r_in;
            peak = 0;
            for (int ch = 0; ch < 2; ch++) begin
                mag = (s[ch] < 0) ? longint'(-s[ch]) : s[ch];
                if (mag > peak) peak = mag;
            end
            fr.last = last;
            if (cfg.bypass) begin
                // pass samples, freeze all state
                fr.left  = l;
                fr.right = r_in;
            end else begin
                tgt    = target_gain(peak_level(peak));
                c      = (tgt < env_gr) ? cfg.attack : cfg.rel_coeff;
                env_gr = tgt + div_round(c * (env_gr - tgt), 65536);
                if (env_gr < block_min) block_min = env_gr;
                // back to linear gain: 2^n times product of roots
                p   = div_round(longint'(env_gr) * 2786635, 65536);
                n   = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
                f   = p - n * 65536;
                lin = 64'd1 << 30;
                for (int k = 1; k <= 16; k++)
                    if ((f >> (16 - k)) & 1) lin = (lin * roots[k]) >> 30;
                sh = 12 - n;
                for (int ch = 0; ch < 2; ch++) begin
                    v = div_round(s[ch] * longint'(lin), 64'sd1 << 30) * longint'(cfg.makeup);
                    if (sh > 0) v = div_round(v, 64'sd1 << sh);
                    else v = v * (64'sd1 << (-sh));
                    if (v > 8388607) v = 8388607;
                    if (v < -8388608) v = -8388608;
                    if (ch == 0) fr.left = v[SB-1:0];
                    else fr.right = v[SB-1:0];
                end
                if (last) begin
                    g = -block_min;
                    if (g > 16383) g = 16383;
                    if (g < 0) g = 0;
                    reported  = g[GR_W-1:0];
                    block_min = 0;
                end
            end
            fr.gr = reported;
            expected_q.push_back(fr);
        endfunction

        function void check_frame(comp_frame_t act);
            comp_frame_t ex;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output frame left=%0d right=%0d gr=%0d last=%0d",
                         $time, act.left, act.right, act.gr, act.last);
                errors++;
                return;
            end
            ex = expected_q.pop_front();
            if (act.left !== ex.left) begin
                $display("%0t: out_left expected %0d got %0d", $time, ex.left, act.left);
                errors++;
            end
            if (act.right !== ex.right) begin
                $display("%0t: out_right expected %0d got %0d", $time, ex.right, act.right);
                errors++;
            end
            if (act.gr !== ex.gr) begin
                $display("%0t: gain_reduction_db expected %0d got %0d", $time, ex.gr, act.gr);
                errors++;
            end
            if (act.last !== ex.last) begin
                $display("%0t: last_out expected %0d got %0d", $time, ex.last, act.last);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic signed [SB-1:0]   i_sample_left;
    logic signed [SB-1:0]   i_sample_right;
    logic                   i_last_in_block;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic signed [SB-1:0]   o_out_left;
    logic signed [SB-1:0]   o_out_right;
    logic [GR_W-1:0]        o_gain_reduction_db;
    logic                   o_last_out;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    compressor_scoreboard   sb;
    bit                     calm;
    longint                 cycles;

    soft_knee_peak_compressor #(
        .SAMPLE_BITS    (SB),
        .LOG_TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_sample_left      (i_sample_left),
        .i_sample_right     (i_sample_right),
        .i_last_in_block    (i_last_in_block),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_left         (o_out_left),
        .o_out_right        (o_out_right),
        .o_gain_reduction_db(o_gain_reduction_db),
        .o_last_out         (o_last_out),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // abort on a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        logic [SB-1:0] v;
        int            e;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: begin
                e = $urandom_range(0, SB - 1);
                v = SB'($urandom & ((32'd1 << (e + 1)) - 1));
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // receiver stalls
    initial begin
        int g;
        i_out_stall = 1'b0;
        forever begin
            g = gap_len();
            if (g > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (g - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
        end
    end

    // check every output transaction
    always @(posedge i_clk) begin
        comp_frame_t act;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            act.left  = o_out_left;
            act.right = o_out_right;
            act.gr    = o_gain_reduction_db;
            act.last  = o_last_out;
            sb.check_frame(act);
        end
    end

    task automatic send_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r, logic last);
        int g;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_sample_left   <= l;
        i_sample_right  <= r;
        i_last_in_block <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_frame(l, r, last);
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drop the input, then hold until every expected frame is out
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic apply_setting(int th, int ir, int kn, int at, int rl, int mk, int bp);
        write_reg(REG_THRESHOLD, CFG_DATA_W'(th));
        write_reg(REG_INV_RATIO, CFG_DATA_W'(ir));
        write_reg(REG_KNEE, CFG_DATA_W'(kn));
        write_reg(REG_ATTACK, CFG_DATA_W'(at));
        write_reg(REG_RELEASE, CFG_DATA_W'(rl));
        write_reg(REG_MAKEUP, CFG_DATA_W'(mk));
        write_reg(REG_BYPASS, CFG_DATA_W'(bp));
    endtask

    task automatic directed_frames();
        send_frame(0, 0, 0);
        send_frame(24'sh7fffff, 0, 0);
        send_frame(-24'sh800000, 0, 0);
        send_frame(0, -24'sh800000, 1);
        send_frame(1, -1, 0);
        send_frame(-1, 0, 1);
        send_frame(24'sh7fffff, -24'sh800000, 0);
        send_frame(24'sh001000, -24'sh010000, 0);
        send_frame(24'sh100000, 24'sh0c0000, 0);
        send_frame(24'sh400000, 24'sh300000, 1);
        send_frame(24'sh000100, 0, 1);
    endtask

    task automatic random_frames(int count, bit pause_midway);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge i_clk);
            end
            send_frame(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
        end
        drain();
    endtask

    initial begin
        sb              = new();
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_sample_left   = '0;
        i_sample_right  = '0;
        i_last_in_block = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, then a soft-knee setting
        directed_frames();
        drain();
        apply_setting(-5120, 16384, 1536, 60000, 65000, 8192, 0);
        directed_frames();
        drain();
        random_frames(100, 1'b1);

        // low threshold, high ratio, wide knee, instant envelope, large makeup
        calm = 1'b1;
        apply_setting(-15360, 3277, 5120, 0, 0, 409600, 0);
        random_frames(100, 1'b0);
        calm = 1'b0;

        // hard knee at unity ratio, slow envelope at unity makeup
        apply_setting(0, 65536, 0, 65535, 65535, 4096, 0);
        random_frames(75, 1'b0);

        // expansion: inv_ratio above unity gives a positive gain target above the threshold
        apply_setting(-15360, 100000, 0, 30000, 50000, 4096, 0);
        random_frames(75, 1'b0);

        // bypass holds envelope and report
        apply_setting(-8000, 8192, 2048, 40000, 64000, 20000, 1);
        random_frames(75, 1'b0);

        // unknown register index is dropped
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

        // full-width random register contents
        for (int ph = 0; ph < 3; ph++) begin
            apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
            random_frames(75, 1'b0);
        end

        // mid setting again after everything
        apply_setting(-2560, 32768, 512, 50000, 65500, 6000, 0);
        random_frames(75, 1'b0);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
